### hdl/ifmt_pkg.sv
`timescale 1ns / 1ps

package ifmt_pkg;

  // Fixed widths of the request fields and of the internal length arithmetic.
  localparam int MAG_W      = 64;
  localparam int BCD_DIGITS = 20;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int LEN_W      = 7;

  // Radix codes.
  localparam logic [1:0] RADIX_BIN = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_DEC = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  // Sign codes.
  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_MINUS = 2'd1;
  localparam logic [1:0] SIGN_PLUS  = 2'd2;
  localparam logic [1:0] SIGN_SPACE = 2'd3;

  // Prefix codes.
  localparam logic [1:0] PREFIX_NONE = 2'd0;
  localparam logic [1:0] PREFIX_ZERO = 2'd1;
  localparam logic [1:0] PREFIX_LX   = 2'd2;
  localparam logic [1:0] PREFIX_UX   = 2'd3;

  // Bit positions in the format flags.
  localparam int FLAG_LEFT_BIT = 0;
  localparam int FLAG_ZERO_BIT = 1;

  // ASCII characters used in a field.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_X  = 8'h78;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_EXTRACT,
    ST_CALC,
    ST_PLAN,
    ST_BOUND,
    ST_PRIME,
    ST_EMIT
  } state_t;

  // Add-3 correction of every BCD digit ahead of a one-bit left shift.
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    logic [3:0]       d;
    r = v;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      d = v[4*i +: 4];
      r[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
    return r;
  endfunction

  // ASCII character of one digit value.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0, d};
    end else begin
      c = (upper ? CH_UP_A : CH_LO_A) + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

### hdl/integer_field_formatter_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// request   in         start high, busy low   in_magnitude .. in_precision
// result    out        out_valid, one cycle   out_char, out_last_char, out_truncated
//
// One request is worked on at a time; busy is high from the cycle after acceptance until
// the last character has been sent. A decimal request first goes through bit-serial binary
// to BCD conversion; then digits are extracted from the low end (up to MAX_DIGITS), the field
// is planned in the states CALC, PLAN, BOUND and PRIME, and the characters are sent (up to
// MAX_FIELD). A zero at precision zero skips conversion and extraction. Synchronous active-low
// reset returns the block to idle. The receiver cannot stall, so characters leave at one per cycle.
module integer_field_formatter_core #(
  parameter int MAX_DIGITS = 64,
  parameter int MAX_FIELD  = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [ifmt_pkg::MAG_W-1:0] in_magnitude,
  input  logic [1:0]                 in_radix_code,
  input  logic                       in_upper_digits,
  input  logic [1:0]                 in_sign_kind,
  input  logic [1:0]                 in_prefix_kind,
  input  logic [1:0]                 in_format_flags,
  input  logic [6:0]                 in_field_width,
  input  logic signed [6:0]          in_precision,
  output logic                       out_valid,
  output logic [7:0]                 out_char,
  output logic                       out_last_char,
  output logic                       out_truncated
);

  import ifmt_pkg::*;

  localparam int NDW   = $clog2(MAX_DIGITS + 1);
  localparam int DAW   = $clog2(MAX_DIGITS);
  localparam int NOW   = $clog2(MAX_FIELD + 1);
  localparam int FAW   = $clog2(MAX_FIELD);
  localparam int CNT_W = $clog2(MAG_W);

  localparam logic [NDW-1:0]   ND_LAST   = NDW'(MAX_DIGITS - 1);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(MAG_W - 1);
  localparam logic [LEN_W-1:0] FIELD_MAX = LEN_W'(MAX_FIELD);

  state_t state_r, state_nxt;

  // Latched request fields.
  logic [1:0]       radix_r;
  logic             upper_r;
  logic [1:0]       sign_r;
  logic [1:0]       prefix_r;
  logic             left_r;
  logic             zflag_r;
  logic [6:0]       width_r;
  logic [5:0]       prec_r;
  logic             has_prec_r;

  // Conversion datapath.
  logic [BCD_W-1:0] work_r;
  logic [MAG_W-1:0] bin_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NDW-1:0]   nd_r;

  // Field plan.
  logic [LEN_W-1:0] dig_tot_r;
  logic [LEN_W-1:0] lsp_r;
  logic [LEN_W-1:0] zp_r;
  logic [NOW-1:0]   n_out_r;
  logic             trunc_r;
  logic [LEN_W-1:0] b1_r, b2_r, b3_r, b4_r, b5_r;
  logic [FAW-1:0]   pos_r;

  // Digit store and its registered read port.
  logic [3:0]       digit_mem [MAX_DIGITS];
  logic [3:0]       rd_q;
  logic [DAW-1:0]   rd_addr;

  logic             skip;
  logic [BCD_W-1:0] shift_w;
  logic [BCD_W-1:0] adj_w;
  logic [3:0]       ext_digit;
  logic             ext_done;
  logic             slen;
  logic [1:0]       plen;
  logic [LEN_W-1:0] nd_ext;
  logic [LEN_W-1:0] prec_ext;
  logic [LEN_W-1:0] body;
  logic [LEN_W-1:0] pad;
  logic [LEN_W-1:0] total;
  logic             zmode;
  logic [LEN_W-1:0] b3_comb;
  logic [LEN_W-1:0] pos_ext;
  logic [FAW-1:0]   pos_nxt;
  logic [LEN_W-1:0] addr_full;
  logic             last_pos;
  logic [7:0]       sign_char;

  // A zero printed at precision zero produces no digits at all.
  assign skip = (in_magnitude == '0) && !in_precision[6] && (in_precision[5:0] == 6'd0);

  // BCD digits corrected ahead of the next double-dabble shift.
  assign adj_w = bcd_adjust(work_r);

  // One digit per cycle from the low end of the work register.
  always_comb begin
    unique case (radix_r)
      RADIX_BIN: begin
        ext_digit = {3'b0, work_r[0]};
        shift_w   = work_r >> 1;
      end
      RADIX_OCT: begin
        ext_digit = {1'b0, work_r[2:0]};
        shift_w   = work_r >> 3;
      end
      RADIX_DEC, RADIX_HEX: begin
        ext_digit = work_r[3:0];
        shift_w   = work_r >> 4;
      end
    endcase
  end

  assign ext_done = (shift_w == '0) || (nd_r == ND_LAST);

  // Lengths of the sign and prefix.
  assign slen = (sign_r != SIGN_NONE);

  always_comb begin
    unique case (prefix_r)
      PREFIX_NONE:           plen = 2'd0;
      PREFIX_ZERO:           plen = 2'd1;
      PREFIX_LX, PREFIX_UX:  plen = 2'd2;
    endcase
  end

  // Padding plan: the body is sign, prefix and the digit run with precision zeros.
  assign nd_ext   = LEN_W'(nd_r);
  assign prec_ext = LEN_W'(prec_r);
  assign body     = dig_tot_r + LEN_W'(slen) + LEN_W'(plen);
  assign zmode    = zflag_r && !left_r && !has_prec_r;

  always_comb begin
    if ({1'b0, width_r} > {1'b0, body}) begin
      pad   = LEN_W'(width_r) - body;
      total = LEN_W'(width_r);
    end else begin
      pad   = '0;
      total = body;
    end
  end

  assign b3_comb = lsp_r + LEN_W'(slen) + LEN_W'(plen);

  // Next output position and the digit address for it, issued ahead through the registered read port.
  assign pos_ext = LEN_W'(pos_r);

  always_comb begin
    if (state_r == ST_EMIT && !last_pos) begin
      pos_nxt = pos_r + FAW'(1);
    end else begin
      pos_nxt = '0;
    end
  end

  assign addr_full = b5_r - LEN_W'(1) - LEN_W'(pos_nxt);
  assign rd_addr   = addr_full[DAW-1:0];
  assign last_pos  = (NOW'(pos_r) == n_out_r - NOW'(1));

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (skip) begin
            state_nxt = ST_CALC;
          end else if (in_radix_code == RADIX_DEC) begin
            state_nxt = ST_DABBLE;
          end else begin
            state_nxt = ST_EXTRACT;
          end
        end
      end
      ST_DABBLE: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_EXTRACT;
        end
      end
      ST_EXTRACT: begin
        if (ext_done) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC:  state_nxt = ST_PLAN;
      ST_PLAN:  state_nxt = ST_BOUND;
      ST_BOUND: state_nxt = ST_PRIME;
      ST_PRIME: begin
        if (n_out_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (last_pos) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    busy          = (state_r != ST_IDLE);
    out_valid     = (state_r == ST_EMIT);
    out_last_char = out_valid && last_pos;
    out_truncated = out_valid && last_pos && trunc_r;
  end

  // Sign character.
  always_comb begin
    unique case (sign_r)
      SIGN_MINUS:             sign_char = CH_MINUS;
      SIGN_PLUS:              sign_char = CH_PLUS;
      SIGN_NONE, SIGN_SPACE:  sign_char = CH_SPACE;
    endcase
  end

  // Character at the current position, chosen by the segment it falls in.
  always_comb begin
    priority if (pos_ext < b1_r) begin
      out_char = CH_SPACE;
    end else if (pos_ext < b2_r) begin
      out_char = sign_char;
    end else if (pos_ext < b3_r) begin
      if (pos_ext == b2_r) begin
        out_char = CH_ZERO;
      end else begin
        out_char = (prefix_r == PREFIX_UX) ? CH_UP_X : CH_LO_X;
      end
    end else if (pos_ext < b4_r) begin
      out_char = CH_ZERO;
    end else if (pos_ext < b5_r) begin
      out_char = digit_char(rd_q, upper_r);
    end else begin
      out_char = CH_SPACE;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      nd_r    <= '0;
      cnt_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      if (state_r == ST_IDLE && start) begin
        nd_r  <= '0;
        cnt_r <= '0;
      end else if (state_r == ST_DABBLE) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (state_r == ST_EXTRACT) begin
        nd_r  <= nd_r + NDW'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          radix_r    <= in_radix_code;
          upper_r    <= in_upper_digits;
          sign_r     <= in_sign_kind;
          prefix_r   <= in_prefix_kind;
          left_r     <= in_format_flags[FLAG_LEFT_BIT];
          zflag_r    <= in_format_flags[FLAG_ZERO_BIT];
          width_r    <= in_field_width;
          prec_r     <= in_precision[5:0];
          has_prec_r <= !in_precision[6];
          bin_r      <= in_magnitude;
          if (in_radix_code == RADIX_DEC) begin
            work_r <= '0;
          end else begin
            work_r <= BCD_W'(in_magnitude);
          end
        end
      end
      ST_DABBLE: begin
        work_r <= {adj_w[BCD_W-2:0], bin_r[MAG_W-1]};
        bin_r  <= bin_r << 1;
      end
      ST_EXTRACT: begin
        work_r <= shift_w;
      end
      ST_CALC: begin
        dig_tot_r <= (has_prec_r && prec_ext > nd_ext) ? prec_ext : nd_ext;
      end
      ST_PLAN: begin
        lsp_r   <= (!left_r && !zmode) ? pad : '0;
        zp_r    <= zmode ? pad : '0;
        trunc_r <= total > FIELD_MAX;
        n_out_r <= (total > FIELD_MAX) ? NOW'(MAX_FIELD) : NOW'(total);
      end
      ST_BOUND: begin
        b1_r <= lsp_r;
        b2_r <= lsp_r + LEN_W'(slen);
        b3_r <= b3_comb;
        b4_r <= b3_comb + zp_r + dig_tot_r - nd_ext;
        b5_r <= b3_comb + zp_r + dig_tot_r;
      end
      default: begin
      end
    endcase
  end

  // Digit store: written during extraction, read one position ahead of output.
  always_ff @(posedge clk) begin
    if (state_r == ST_EXTRACT) begin
      digit_mem[nd_r[DAW-1:0]] <= ext_digit;
    end
    rd_q <= digit_mem[rd_addr];
  end

endmodule
